// File: rtl/cbm_pkg.sv
// Shared types and constants of the cartridge bank mapper.
package cbm_pkg;

  localparam int ChrWindows = 8;
  localparam int PrgWindows = 3;
  localparam int QueueDepth = 2;
  localparam int CfgAddrW = 3;

  localparam logic [7:0] LastPrgReset = 8'd31;
  localparam logic [7:0] PrgBank2Reset = 8'((LastPrgReset - 8'd1) & 8'h7F);

  typedef enum logic [1:0] {
    FUNC_CPU_WRITE = 2'd0,
    FUNC_TICK      = 2'd1,
    FUNC_CPU_READ  = 2'd2,
    FUNC_PPU_READ  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SET_CHR,
    OP_SET_PRG,
    OP_SET_MIRROR,
    OP_SET_RELOAD,
    OP_LOAD_COUNT,
    OP_SET_ENABLE,
    OP_TICK,
    OP_PRG_READ,
    OP_CHR_READ
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  idx;
    logic [7:0]  data;
    logic [12:0] offset;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: rtl/cbm_if.sv
// Valid/ready channel interfaces for mapper items and mapper results.
interface cbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [15:0] bus_address;
  logic [7:0] write_data;
  logic [8:0] scanline_number;
  logic       rendering_on;

  modport source (output valid, func, bus_address, write_data, scanline_number, rendering_on,
                  input ready);
  modport sink (input valid, func, bus_address, write_data, scanline_number, rendering_on,
                output ready);
endinterface

interface cbm_out_if;
  logic        valid;
  logic        ready;
  logic        irq_pulse;
  logic [20:0] mapped_address;
  logic [1:0]  mirror_mode;

  modport source (output valid, irq_pulse, mapped_address, mirror_mode, input ready);
  modport sink (input valid, irq_pulse, mapped_address, mirror_mode, output ready);
endinterface

// File: rtl/cbm_front.sv
// Front end: accepts items and decodes them into mapper commands.
module cbm_front #(
  parameter int LAST_VISIBLE_LINE = 240
) (
  cbm_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output cbm_pkg::cmd_t   cmd_o
);

  localparam logic [8:0] LastLine = 9'(LAST_VISIBLE_LINE);
  localparam logic [2:0] GrpChr = 3'b000;
  localparam logic [2:0] GrpCtl = 3'b001;
  localparam logic [2:0] RegPrg0 = 3'd0;
  localparam logic [2:0] RegPrg1 = 3'd1;
  localparam logic [2:0] RegPrg2 = 3'd2;
  localparam logic [2:0] RegMirror = 3'd4;
  localparam logic [2:0] RegReload = 3'd5;
  localparam logic [2:0] RegCounter = 3'd6;
  localparam logic [2:0] RegEnable = 3'd7;

  logic [15:0] addr;

  assign addr = in_i.bus_address;
  assign in_i.ready = !full_i;
  assign push_o = in_i.valid && !full_i;

  always_comb begin
    cmd_o.op = cbm_pkg::OP_NOP;
    cmd_o.idx = addr[2:0];
    cmd_o.data = in_i.write_data;
    cmd_o.offset = addr[12:0];
    case (cbm_pkg::func_e'(in_i.func))
      cbm_pkg::FUNC_CPU_WRITE: begin
        if (addr[15]) begin
          if (addr[14:12] == GrpChr) begin
            cmd_o.op = cbm_pkg::OP_SET_CHR;
          end else if (addr[14:12] == GrpCtl) begin
            case (addr[2:0])
              RegPrg0, RegPrg1, RegPrg2: cmd_o.op = cbm_pkg::OP_SET_PRG;
              RegMirror: cmd_o.op = cbm_pkg::OP_SET_MIRROR;
              RegReload: cmd_o.op = cbm_pkg::OP_SET_RELOAD;
              RegCounter: cmd_o.op = cbm_pkg::OP_LOAD_COUNT;
              RegEnable: cmd_o.op = cbm_pkg::OP_SET_ENABLE;
              default: cmd_o.op = cbm_pkg::OP_NOP;
            endcase
          end
        end
      end
      cbm_pkg::FUNC_TICK: begin
        if (in_i.scanline_number <= LastLine && in_i.rendering_on) begin
          cmd_o.op = cbm_pkg::OP_TICK;
        end
      end
      cbm_pkg::FUNC_CPU_READ: begin
        if (addr[15]) begin
          cmd_o.op = cbm_pkg::OP_PRG_READ;
          cmd_o.idx = {1'b0, addr[14:13]};
        end
      end
      cbm_pkg::FUNC_PPU_READ: begin
        if (addr[15:13] == 3'b000) begin
          cmd_o.op = cbm_pkg::OP_CHR_READ;
          cmd_o.idx = addr[12:10];
        end
      end
      default: cmd_o.op = cbm_pkg::OP_NOP;
    endcase
  end

endmodule

// File: rtl/cbm_queue.sv
// Short command queue between the decode front end and the execution back end.
module cbm_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cbm_pkg::cmd_t          cmd_i,
  input  logic                   pop_i,
  output cbm_pkg::cmd_t          cmd_o,
  output cbm_pkg::queue_status_t status_o
);

  localparam int PtrW = $clog2(cbm_pkg::QueueDepth);
  localparam int CntW = $clog2(cbm_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(cbm_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(cbm_pkg::QueueDepth - 1);

  cbm_pkg::cmd_t   mem_q [cbm_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.full = (count_q == DepthCnt);
  assign status_o.empty = (count_q == '0);
  assign cmd_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !status_o.full;
  assign do_pop = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/cbm_back.sv
// Back end: holds the bank, mirroring and interrupt state and produces results.
module cbm_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             last_prg_i,
  input  cbm_pkg::cmd_t          cmd_i,
  input  cbm_pkg::queue_status_t status_i,
  output logic                   pop_o,
  cbm_out_if.source              out_o
);

  logic [7:0]  prg_q [cbm_pkg::PrgWindows];
  logic [7:0]  chr_q [cbm_pkg::ChrWindows];
  logic [1:0]  mirror_q, mirror_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  reload_q, reload_d;
  logic        enable_q, enable_d;
  logic        pending_q, pending_d;
  logic        pulse_d;
  logic [20:0] mapped_d;
  logic [7:0]  cnt_cur, cnt_dec, win_bank;
  logic        out_valid_q;
  logic        out_pulse_q;
  logic [20:0] out_mapped_q;
  logic [1:0]  out_mirror_q;

  assign pop_o = !status_i.empty && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.irq_pulse = out_pulse_q;
  assign out_o.mapped_address = out_mapped_q;
  assign out_o.mirror_mode = out_mirror_q;

  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0: win_bank = prg_q[0];
      2'd1: win_bank = prg_q[1];
      2'd2: win_bank = prg_q[2];
      default: win_bank = last_prg_i;
    endcase
  end

  assign cnt_cur = pending_q ? reload_q : count_q;
  assign cnt_dec = cnt_cur - 8'd1;

  always_comb begin
    mirror_d = mirror_q;
    count_d = count_q;
    reload_d = reload_q;
    enable_d = enable_q;
    pending_d = pending_q;
    pulse_d = 1'b0;
    mapped_d = '0;
    case (cmd_i.op)
      cbm_pkg::OP_SET_MIRROR: mirror_d = cmd_i.data[1:0];
      cbm_pkg::OP_SET_RELOAD: reload_d = cmd_i.data;
      cbm_pkg::OP_LOAD_COUNT: begin
        count_d = reload_q;
        pending_d = 1'b0;
      end
      cbm_pkg::OP_SET_ENABLE: begin
        enable_d = cmd_i.data[0];
        if (cmd_i.data[0]) begin
          pending_d = 1'b1;
        end
      end
      cbm_pkg::OP_TICK: begin
        if (enable_q) begin
          pending_d = 1'b0;
          count_d = cnt_cur;
          if (cnt_cur != 8'd0) begin
            if (cnt_dec == 8'd0) begin
              count_d = reload_q;
              pulse_d = 1'b1;
            end else begin
              count_d = cnt_dec;
            end
          end
        end
      end
      cbm_pkg::OP_PRG_READ: mapped_d = {win_bank, cmd_i.offset};
      cbm_pkg::OP_CHR_READ: mapped_d = {3'b000, chr_q[cmd_i.idx], cmd_i.offset[9:0]};
      default: mapped_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_q[0] <= 8'd0;
      prg_q[1] <= 8'd1;
      prg_q[2] <= cbm_pkg::PrgBank2Reset;
      for (int i = 0; i < cbm_pkg::ChrWindows; i++) begin
        chr_q[i] <= 8'(i);
      end
      mirror_q <= '0;
      count_q <= '0;
      reload_q <= '0;
      enable_q <= 1'b0;
      pending_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (cmd_i.op == cbm_pkg::OP_SET_CHR) begin
          chr_q[cmd_i.idx] <= cmd_i.data;
        end
        if (cmd_i.op == cbm_pkg::OP_SET_PRG) begin
          case (cmd_i.idx[1:0])
            2'd0: prg_q[0] <= cmd_i.data;
            2'd1: prg_q[1] <= cmd_i.data;
            default: prg_q[2] <= cmd_i.data;
          endcase
        end
        mirror_q <= mirror_d;
        count_q <= count_d;
        reload_q <= reload_d;
        enable_q <= enable_d;
        pending_q <= pending_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_pulse_q <= pulse_d;
      out_mapped_q <= mapped_d;
      out_mirror_q <= mirror_d;
    end
  end

endmodule

// File: rtl/cartridge_bank_mapper_scanline_irq_unit.sv
// Cartridge bank mapper with scanline interrupt counter: top level.
// The unit takes one item per clock cycle while the command queue is not full
// and returns exactly one result per item, in order. Each item is decoded in
// the cycle of its transfer and written into the command queue, then executed
// from the queue into the output register when the back end pops it. The
// two-entry command queue and the output register let either side stall
// without stopping the other. The last PRG bank register is selected by
// configuration addresses 0 to 3, where paddr[2] is low.
module cartridge_bank_mapper_scanline_irq_unit #(
  parameter int LAST_VISIBLE_LINE = 240
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cbm_in_if.sink                       in_i,
  cbm_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbm_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic                   last_prg_sel;
  logic                   cfg_write;
  logic [7:0]             last_prg_q;
  logic                   push;
  logic                   pop;
  cbm_pkg::cmd_t          front_cmd;
  cbm_pkg::cmd_t          back_cmd;
  cbm_pkg::queue_status_t q_status;

  assign pready = 1'b1;
  assign last_prg_sel = (paddr[cbm_pkg::CfgAddrW-1] == 1'b0);
  assign cfg_write = psel && penable && pwrite && pready && last_prg_sel;
  assign prdata = last_prg_sel ? {24'd0, last_prg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_prg_q <= cbm_pkg::LastPrgReset;
    end else if (cfg_write) begin
      last_prg_q <= pwdata[7:0];
    end
  end

  cbm_front #(
    .LAST_VISIBLE_LINE(LAST_VISIBLE_LINE)
  ) u_front (
    .in_i   (in_i),
    .full_i (q_status.full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  cbm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (back_cmd),
    .status_o (q_status)
  );

  cbm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .last_prg_i (last_prg_q),
    .cmd_i      (back_cmd),
    .status_i   (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("command queue reports full and empty at once");

  a_pulse_no_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.irq_pulse) |-> (out_o.mapped_address == 21'd0))
    else $error("interrupt result carries a translated address");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> (last_prg_q == $past(pwdata[7:0])))
    else $error("last PRG bank register missed a configuration write");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("back end took a command from an empty queue");

endmodule
